// ===== rtl/lpbc_pkg.sv =====
// shared types and constants for the lattice point ball counter
`default_nettype none

package lpbc_pkg;

  localparam int DIM_BITS   = 4;
  localparam int PASS_BITS  = DIM_BITS + 1;
  localparam int LIMIT_BITS = 12;
  localparam int SQ_BITS    = LIMIT_BITS + 1;
  localparam int ODD_BITS   = 8;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_INIT,
    ST_PASS_RD0,
    ST_PASS_RD,
    ST_PASS_WR,
    ST_PRE,
    ST_PRE_DRAIN,
    ST_SUM,
    ST_SUM_DRAIN,
    ST_DONE
  } ctrl_state_e;

  typedef enum logic [2:0] {
    RD_NONE,
    RD_LOAD,
    RD_ADD2,
    RD_PRE,
    RD_TOT
  } rd_op_e;

  typedef struct packed {
    logic   load_job;
    logic   s_clr;
    logic   s_inc;
    logic   init_wr;
    rd_op_e rd_op;
    logic   inner_start;
    logic   inner_step;
    logic   pass_wr;
    logic   swap;
    logic   pass_dec;
    logic   x_start;
    logic   x_inc;
    logic   out_load;
  } dp_cmd_t;

  typedef struct packed {
    logic s_last;
    logic inner_more;
    logic passes_zero;
    logic passes_last;
    logic range_empty;
    logic x_last;
    logic x_in_ball;
  } dp_sts_t;

endpackage

`default_nettype wire

// ===== rtl/lpbc_ctrl.sv =====
// sequencing state machine for the lattice point ball counter
`default_nettype none

module lpbc_ctrl (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  output logic                  in_stall_o,
  output logic                  out_valid_o,
  input  wire logic             out_stall_i,
  output lpbc_pkg::dp_cmd_t     cmd_o,
  input  wire lpbc_pkg::dp_sts_t sts_i
);
  import lpbc_pkg::*;

  ctrl_state_e state_q, state_d;
  logic        out_valid_q, out_valid_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    cmd_o.rd_op = RD_NONE;
    out_valid_d = out_valid_q && out_stall_i;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load_job = 1'b1;
          state_d        = ST_INIT;
        end
      end
      ST_INIT: begin
        // seed the zero-dimension table: one way to reach sum zero
        cmd_o.init_wr = 1'b1;
        if (sts_i.s_last) begin
          cmd_o.s_clr = 1'b1;
          state_d     = sts_i.passes_zero ? ST_PRE : ST_PASS_RD0;
        end else begin
          cmd_o.s_inc = 1'b1;
        end
      end
      ST_PASS_RD0: begin
        cmd_o.rd_op       = RD_LOAD;
        cmd_o.inner_start = 1'b1;
        state_d           = ST_PASS_RD;
      end
      ST_PASS_RD: begin
        if (sts_i.inner_more) begin
          cmd_o.rd_op      = RD_ADD2;
          cmd_o.inner_step = 1'b1;
        end else begin
          state_d = ST_PASS_WR;
        end
      end
      ST_PASS_WR: begin
        cmd_o.pass_wr = 1'b1;
        if (sts_i.s_last) begin
          cmd_o.s_clr    = 1'b1;
          cmd_o.swap     = 1'b1;
          cmd_o.pass_dec = 1'b1;
          state_d        = sts_i.passes_last ? ST_PRE : ST_PASS_RD0;
        end else begin
          cmd_o.s_inc = 1'b1;
          state_d     = ST_PASS_RD0;
        end
      end
      ST_PRE: begin
        cmd_o.rd_op = RD_PRE;
        if (sts_i.s_last) begin
          state_d = ST_PRE_DRAIN;
        end else begin
          cmd_o.s_inc = 1'b1;
        end
      end
      ST_PRE_DRAIN: begin
        cmd_o.swap    = 1'b1;
        cmd_o.x_start = 1'b1;
        state_d       = sts_i.range_empty ? ST_DONE : ST_SUM;
      end
      ST_SUM: begin
        if (sts_i.x_in_ball) begin
          cmd_o.rd_op = RD_TOT;
        end
        if (sts_i.x_last) begin
          state_d = ST_SUM_DRAIN;
        end else begin
          cmd_o.x_inc = 1'b1;
        end
      end
      ST_SUM_DRAIN: begin
        state_d = ST_DONE;
      end
      ST_DONE: begin
        if (!out_valid_q || !out_stall_i) begin
          cmd_o.out_load = 1'b1;
          out_valid_d    = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;

endmodule

`default_nettype wire

// ===== rtl/lpbc_datapath.sv =====
// count tables, counters and saturating adders of the lattice point ball counter
`default_nettype none

module lpbc_datapath #(
  parameter int MAX_DIM    = 8,
  parameter int COORD_BITS = 7,
  parameter int COUNT_BITS = 56
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire lpbc_pkg::dp_cmd_t                 cmd_i,
  output lpbc_pkg::dp_sts_t                      sts_o,
  input  wire logic [lpbc_pkg::DIM_BITS-1:0]     dimension_i,
  input  wire logic [lpbc_pkg::LIMIT_BITS-1:0]   radius_limit_i,
  input  wire logic signed [COORD_BITS-1:0]      first_low_i,
  input  wire logic signed [COORD_BITS-1:0]      first_high_i,
  output logic [COUNT_BITS-1:0]                  point_count_o,
  output logic                                   count_saturated_o
);
  import lpbc_pkg::*;

  localparam int ENTRY_BITS = COUNT_BITS + 1;
  localparam int DEPTH      = 1 << LIMIT_BITS;
  localparam int XBITS      = COORD_BITS + 1;
  localparam int PROD_BITS  = 2 * XBITS;
  localparam int CMP_BITS   = (PROD_BITS > LIMIT_BITS) ? PROD_BITS : LIMIT_BITS + 1;

  // job registers
  logic [LIMIT_BITS-1:0]        limit_q;
  logic signed [COORD_BITS-1:0] lo_q, hi_q;
  logic [PASS_BITS-1:0]         passes_q;
  logic [PASS_BITS-1:0]         dim_ext, dim_clamp;

  // sweep counters
  logic [LIMIT_BITS-1:0]        s_q;
  logic [SQ_BITS-1:0]           ysq_q;
  logic [ODD_BITS-1:0]          odd_q;
  logic                         bank_q;
  logic signed [XBITS-1:0]      x_q;
  logic signed [PROD_BITS-1:0]  sq_s;
  logic [CMP_BITS-1:0]          sq_ext;

  // accumulators
  logic [COUNT_BITS-1:0]        acc_q, run_q, total_q;
  logic                         acc_over_q, run_over_q, total_over_q;
  logic [COUNT_BITS-1:0]        run_d;
  logic                         run_over_d;
  logic [COUNT_BITS+1:0]        sum2;
  logic [COUNT_BITS:0]          sum_run, sum_tot;

  // tables, one holds the source counts and the other takes the next ones
  logic [ENTRY_BITS-1:0]        mem0_q [DEPTH];
  logic [ENTRY_BITS-1:0]        mem1_q [DEPTH];
  logic [ENTRY_BITS-1:0]        rd0_data_q, rd1_data_q, rd_data;
  logic [LIMIT_BITS-1:0]        rd_addr, rd_addr_q, wr_addr;
  logic                         rd_bank_q;
  rd_op_e                       rd_op_q;
  logic                         wr_en, wr_bank;
  logic [ENTRY_BITS-1:0]        wr_data;
  logic [COUNT_BITS-1:0]        d_cnt;
  logic                         d_over;

  logic [COUNT_BITS-1:0]        point_count_q;
  logic                         count_saturated_q;

  // dimension clamp: zero counts as one, large values stop at the maximum
  always_comb begin
    dim_ext = {1'b0, dimension_i};
    if (dim_ext == '0) begin
      dim_clamp = PASS_BITS'(1);
    end else if (dim_ext > PASS_BITS'(MAX_DIM)) begin
      dim_clamp = PASS_BITS'(MAX_DIM);
    end else begin
      dim_clamp = dim_ext;
    end
  end

  assign sq_s   = x_q * x_q;
  assign sq_ext = CMP_BITS'($unsigned(sq_s));

  assign sts_o.s_last      = (s_q == limit_q);
  assign sts_o.inner_more  = (ysq_q <= {1'b0, s_q});
  assign sts_o.passes_zero = (passes_q == '0);
  assign sts_o.passes_last = (passes_q == PASS_BITS'(1));
  assign sts_o.range_empty = (lo_q > hi_q);
  assign sts_o.x_last      = (x_q == {hi_q[COORD_BITS-1], hi_q});
  assign sts_o.x_in_ball   = (sq_ext <= CMP_BITS'(limit_q));

  always_comb begin
    case (cmd_i.rd_op)
      RD_ADD2: rd_addr = s_q - ysq_q[LIMIT_BITS-1:0];
      RD_TOT:  rd_addr = limit_q - sq_ext[LIMIT_BITS-1:0];
      default: rd_addr = s_q;
    endcase
  end

  assign rd_data = rd_bank_q ? rd1_data_q : rd0_data_q;
  assign d_cnt   = rd_data[COUNT_BITS-1:0];
  assign d_over  = rd_data[COUNT_BITS];

  // saturating adders, the count ceiling is all ones
  assign sum2    = {2'b00, acc_q} + {1'b0, d_cnt, 1'b0};
  assign sum_run = {1'b0, run_q} + {1'b0, d_cnt};
  assign sum_tot = {1'b0, total_q} + {1'b0, d_cnt};

  always_comb begin
    if (rd_addr_q == '0) begin
      run_d      = d_cnt;
      run_over_d = d_over;
    end else if (run_over_q || d_over || sum_run[COUNT_BITS]) begin
      run_d      = '1;
      run_over_d = 1'b1;
    end else begin
      run_d      = sum_run[COUNT_BITS-1:0];
      run_over_d = 1'b0;
    end
  end

  always_comb begin
    wr_en   = 1'b0;
    wr_bank = bank_q;
    wr_addr = s_q;
    wr_data = '0;
    if (cmd_i.init_wr) begin
      wr_en   = 1'b1;
      wr_data = (s_q == '0) ? ENTRY_BITS'(1) : '0;
    end else if (cmd_i.pass_wr) begin
      wr_en   = 1'b1;
      wr_bank = ~bank_q;
      wr_data = {acc_over_q, acc_q};
    end else if (rd_op_q == RD_PRE) begin
      wr_en   = 1'b1;
      wr_bank = ~bank_q;
      wr_addr = rd_addr_q;
      wr_data = {run_over_d, run_d};
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en && !wr_bank) begin
      mem0_q[wr_addr] <= wr_data;
    end
    rd0_data_q <= mem0_q[rd_addr];
  end

  always_ff @(posedge clk_i) begin
    if (wr_en && wr_bank) begin
      mem1_q[wr_addr] <= wr_data;
    end
    rd1_data_q <= mem1_q[rd_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_op_q <= RD_NONE;
    end else begin
      rd_op_q <= cmd_i.rd_op;
    end
  end

  always_ff @(posedge clk_i) begin
    rd_addr_q <= rd_addr;
    rd_bank_q <= bank_q;

    if (cmd_i.load_job) begin
      limit_q  <= radius_limit_i;
      lo_q     <= first_low_i;
      hi_q     <= first_high_i;
      passes_q <= dim_clamp - PASS_BITS'(1);
      bank_q   <= 1'b0;
    end else begin
      if (cmd_i.pass_dec) begin
        passes_q <= passes_q - PASS_BITS'(1);
      end
      if (cmd_i.swap) begin
        bank_q <= ~bank_q;
      end
    end

    if (cmd_i.load_job || cmd_i.s_clr) begin
      s_q <= '0;
    end else if (cmd_i.s_inc) begin
      s_q <= s_q + LIMIT_BITS'(1);
    end

    // next square y*y and the odd step to the one after it
    if (cmd_i.inner_start) begin
      ysq_q <= SQ_BITS'(1);
      odd_q <= ODD_BITS'(3);
    end else if (cmd_i.inner_step) begin
      ysq_q <= ysq_q + SQ_BITS'(odd_q);
      odd_q <= odd_q + ODD_BITS'(2);
    end

    if (cmd_i.x_start) begin
      x_q          <= {lo_q[COORD_BITS-1], lo_q};
      total_q      <= '0;
      total_over_q <= 1'b0;
    end else if (cmd_i.x_inc) begin
      x_q <= x_q + XBITS'(1);
    end

    case (rd_op_q)
      RD_LOAD: begin
        acc_q      <= d_cnt;
        acc_over_q <= d_over;
      end
      RD_ADD2: begin
        if (acc_over_q || d_over || (sum2[COUNT_BITS+1:COUNT_BITS] != 2'b00)) begin
          acc_q      <= '1;
          acc_over_q <= 1'b1;
        end else begin
          acc_q <= sum2[COUNT_BITS-1:0];
        end
      end
      RD_PRE: begin
        run_q      <= run_d;
        run_over_q <= run_over_d;
      end
      RD_TOT: begin
        if (total_over_q || d_over || sum_tot[COUNT_BITS]) begin
          total_q      <= '1;
          total_over_q <= 1'b1;
        end else begin
          total_q <= sum_tot[COUNT_BITS-1:0];
        end
      end
      default: begin
      end
    endcase

    if (cmd_i.out_load) begin
      point_count_q     <= total_q;
      count_saturated_q <= total_over_q;
    end
  end

  assign point_count_o     = point_count_q;
  assign count_saturated_o = count_saturated_q;

endmodule

`default_nettype wire

// ===== rtl/lattice_point_ball_counter_core.sv =====
// top level of the lattice point ball counter
`default_nettype none

// Counts the integer points (x1..xd) with x1^2 + ... + xd^2 <= radius_limit and
// first_low <= x1 <= first_high, one job per input word and one result word per
// job. The count saturates at all ones and count_saturated_o then reads 1. A
// dimension of zero is taken as one, a dimension above MAX_DIM as MAX_DIM.
// The job runs in four phases over two count tables of 2^12 entries held in
// on-chip memory (one write and one read port each, read data registered):
// seeding the table; the d-1 dimension passes, each with one table read per
// square up to s for every sum s in the single accumulate loop; the running
// prefix sum; and the final sum over the first coordinate, after which the
// output register is loaded. A new job is taken only while the block is idle;
// a finished result waits in the output register and does not hold up the
// next job until that job itself finishes.

module lattice_point_ball_counter_core #(
  parameter int MAX_DIM    = 8,
  parameter int COORD_BITS = 7,
  parameter int COUNT_BITS = 56
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  // job word
  input  wire logic                            in_valid_i,
  output logic                                 in_stall_o,
  input  wire logic [lpbc_pkg::DIM_BITS-1:0]   dimension_i,
  input  wire logic [lpbc_pkg::LIMIT_BITS-1:0] radius_limit_i,
  input  wire logic signed [COORD_BITS-1:0]    first_low_i,
  input  wire logic signed [COORD_BITS-1:0]    first_high_i,
  // result word
  output logic                                 out_valid_o,
  input  wire logic                            out_stall_i,
  output logic [COUNT_BITS-1:0]                point_count_o,
  output logic                                 count_saturated_o
);
  import lpbc_pkg::*;

  dp_cmd_t cmd;
  dp_sts_t sts;

  // phase sequencing and both handshakes
  lpbc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .cmd_o       (cmd),
    .sts_i       (sts)
  );

  // tables, counters, saturating adders and the result register
  lpbc_datapath #(
    .MAX_DIM    (MAX_DIM),
    .COORD_BITS (COORD_BITS),
    .COUNT_BITS (COUNT_BITS)
  ) u_datapath (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_i             (cmd),
    .sts_o             (sts),
    .dimension_i       (dimension_i),
    .radius_limit_i    (radius_limit_i),
    .first_low_i       (first_low_i),
    .first_high_i      (first_high_i),
    .point_count_o     (point_count_o),
    .count_saturated_o (count_saturated_o)
  );

endmodule

`default_nettype wire

// ===== rtl/lpbc_checker.sv =====
// port checks for the lattice point ball counter and their bind
`default_nettype none

module lpbc_checker #(
  parameter int COUNT_BITS = 56
) (
  input wire logic                  clk_i,
  input wire logic                  rst_ni,
  input wire logic                  in_valid_i,
  input wire logic                  in_stall_o,
  input wire logic                  out_valid_o,
  input wire logic                  out_stall_i,
  input wire logic [COUNT_BITS-1:0] point_count_o,
  input wire logic                  count_saturated_o
);

  // a taken job keeps the input side busy in the next cycle
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input not stalled after job accepted");

  a_out_valid_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result word dropped while stalled");

  a_out_payload_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(point_count_o) && $stable(count_saturated_o))
    else $error("result word changed while stalled");

  // a saturated result sits at the ceiling
  a_sat_at_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && count_saturated_o |-> (&point_count_o))
    else $error("saturated result below ceiling");

endmodule

bind lattice_point_ball_counter_core lpbc_checker #(
  .COUNT_BITS (COUNT_BITS)
) u_lpbc_checker (
  .clk_i             (clk_i),
  .rst_ni            (rst_ni),
  .in_valid_i        (in_valid_i),
  .in_stall_o        (in_stall_o),
  .out_valid_o       (out_valid_o),
  .out_stall_i       (out_stall_i),
  .point_count_o     (point_count_o),
  .count_saturated_o (count_saturated_o)
);

`default_nettype wire
